/* src/bda_pkg.sv */
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the button debounce / autorepeat block.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int RAW_W   = 5;
    localparam int JOY_W   = 12;
    localparam int MASK_W  = 9;
    localparam int INT_W   = 8;
    localparam int STEP_W  = 8;
    localparam int CNT_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // held/press bit positions of the joystick directions
    localparam int BIT_RIGHT = 5;
    localparam int BIT_LEFT  = 6;
    localparam int BIT_UP    = 7;
    localparam int BIT_DOWN  = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_UP        = 3'd0,
        CFG_STEP_DOWN      = 3'd1,
        CFG_UPPER_PRESS    = 3'd2,
        CFG_UPPER_RELEASE  = 3'd3,
        CFG_LOWER_PRESS    = 3'd4,
        CFG_LOWER_RELEASE  = 3'd5,
        CFG_REPEAT_INITIAL = 3'd6,
        CFG_REPEAT_PERIOD  = 3'd7
    } cfg_idx_t;

    localparam logic [STEP_W-1:0] RST_STEP_UP        = 8'd1;
    localparam logic [STEP_W-1:0] RST_STEP_DOWN      = 8'd1;
    localparam logic [JOY_W-1:0]  RST_UPPER_PRESS    = 12'd3000;
    localparam logic [JOY_W-1:0]  RST_UPPER_RELEASE  = 12'd2800;
    localparam logic [JOY_W-1:0]  RST_LOWER_PRESS    = 12'd1000;
    localparam logic [JOY_W-1:0]  RST_LOWER_RELEASE  = 12'd1200;
    localparam logic [CNT_W-1:0]  RST_REPEAT_INITIAL = 10'd100;
    localparam logic [CNT_W-1:0]  RST_REPEAT_PERIOD  = 10'd10;

    typedef struct packed {
        logic [STEP_W-1:0] step_up;
        logic [STEP_W-1:0] step_down;
        logic [JOY_W-1:0]  upper_press;
        logic [JOY_W-1:0]  upper_release;
        logic [JOY_W-1:0]  lower_press;
        logic [JOY_W-1:0]  lower_release;
        logic [CNT_W-1:0]  repeat_initial;
        logic [CNT_W-1:0]  repeat_period;
    } cfg_t;

endpackage

/* src/bda_if.sv */
// ----------------------------------------------------------------------------
// bda_if
// Valid/ready channels for scan samples and debounced results.
// ----------------------------------------------------------------------------
interface bda_in_if;
    logic                      valid;
    logic                      ready;
    logic [bda_pkg::RAW_W-1:0] raw_buttons;
    logic [bda_pkg::JOY_W-1:0] joy_x;
    logic [bda_pkg::JOY_W-1:0] joy_y;

    modport source (output valid, output raw_buttons, output joy_x, output joy_y,
                    input ready);
    modport sink   (input valid, input raw_buttons, input joy_x, input joy_y,
                    output ready);
endinterface

interface bda_out_if;
    logic                       valid;
    logic                       ready;
    logic [bda_pkg::MASK_W-1:0] held_mask;
    logic [bda_pkg::MASK_W-1:0] press_mask;

    modport source (output valid, output held_mask, output press_mask, input ready);
    modport sink   (input valid, input held_mask, input press_mask, output ready);
endinterface

/* src/button_debounce_autorepeat.sv */
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// Integrator debounce of five buttons, joystick threshold hysteresis and
// per-channel autorepeat, one scan word per clock while result is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one scan tick per word (raw_buttons, joy_x, joy_y).
//   result : one word per tick (held_mask, press_mask), same order.
//   cfg_*  : register writes, index 0..7, taken on any edge with cfg_we high;
//            write only while no word is in flight.
// Timing:
//   A word lands in the input register, is evaluated there against the channel
//   state and is then registered into the result register: throughput 1 word
//   per cycle while result is not stalled. The rate is set by the update of
//   the integrator / hold counter state, done in full as each word is taken.
// Reset:
//   rst_n clears integrators, held bits, hold counts and phases and loads
//   the register defaults. No clearing pass is needed.
// Stall:
//   While result is stalled the result register holds, one more word waits
//   in the input register, and then sample.ready drops.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat #(
    parameter int NUM_BUTTONS    = 5,
    parameter int NUM_CHANNELS   = 9,
    parameter int DEBOUNCE_LEVEL = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bda_in_if.sink                        sample,
    bda_out_if.source                     result,
    input  logic                          cfg_we,
    input  logic [bda_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bda_pkg::*;

    localparam logic [MASK_W-1:0] CHAN_MASK = MASK_W'((1 << NUM_CHANNELS) - 1);
    localparam logic [MASK_W-1:0] BTN_OFF   =
        MASK_W'(RAW_W'('1) & ~RAW_W'((1 << NUM_BUTTONS) - 1));
    localparam logic [MASK_W-1:0] KEEP_MASK = CHAN_MASK & ~BTN_OFF;
    localparam logic [INT_W-1:0]  LEVEL     = INT_W'(DEBOUNCE_LEVEL);

    cfg_t cfg_reg;

    // input register
    logic             s1_valid_reg;
    logic [RAW_W-1:0] raw_reg;
    logic [JOY_W-1:0] jx_reg;
    logic [JOY_W-1:0] jy_reg;

    // result register
    logic              out_valid_reg;
    logic [MASK_W-1:0] held_out_reg;
    logic [MASK_W-1:0] press_out_reg;

    // channel state
    logic [INT_W-1:0]  int_reg   [RAW_W];
    logic [INT_W-1:0]  int_next  [RAW_W];
    logic [MASK_W-1:0] held_reg;
    logic [MASK_W-1:0] held_next;
    logic [CNT_W-1:0]  cnt_reg   [MASK_W];
    logic [CNT_W-1:0]  cnt_next  [MASK_W];
    logic [CNT_W-1:0]  phase_reg [MASK_W];
    logic [CNT_W-1:0]  phase_next[MASK_W];
    logic [MASK_W-1:0] repeats;
    logic [MASK_W-1:0] press;

    logic advance;
    logic take;

    assign advance      = !out_valid_reg || result.ready;
    assign take         = s1_valid_reg && advance;
    assign sample.ready = !s1_valid_reg || advance;

    assign result.valid      = out_valid_reg;
    assign result.held_mask  = held_out_reg;
    assign result.press_mask = press_out_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_up        <= RST_STEP_UP;
            cfg_reg.step_down      <= RST_STEP_DOWN;
            cfg_reg.upper_press    <= RST_UPPER_PRESS;
            cfg_reg.upper_release  <= RST_UPPER_RELEASE;
            cfg_reg.lower_press    <= RST_LOWER_PRESS;
            cfg_reg.lower_release  <= RST_LOWER_RELEASE;
            cfg_reg.repeat_initial <= RST_REPEAT_INITIAL;
            cfg_reg.repeat_period  <= RST_REPEAT_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STEP_UP:        cfg_reg.step_up        <= cfg_data[STEP_W-1:0];
                CFG_STEP_DOWN:      cfg_reg.step_down      <= cfg_data[STEP_W-1:0];
                CFG_UPPER_PRESS:    cfg_reg.upper_press    <= cfg_data[JOY_W-1:0];
                CFG_UPPER_RELEASE:  cfg_reg.upper_release  <= cfg_data[JOY_W-1:0];
                CFG_LOWER_PRESS:    cfg_reg.lower_press    <= cfg_data[JOY_W-1:0];
                CFG_LOWER_RELEASE:  cfg_reg.lower_release  <= cfg_data[JOY_W-1:0];
                CFG_REPEAT_INITIAL: cfg_reg.repeat_initial <= cfg_data[CNT_W-1:0];
                CFG_REPEAT_PERIOD:  cfg_reg.repeat_period  <= cfg_data[CNT_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        logic [INT_W:0]  sum;
        logic            bumped;
        logic [CNT_W-1:0] c;
        logic [CNT_W:0]  p;
        logic [MASK_W-1:0] h;

        h = held_reg;

        for (int i = 0; i < RAW_W; i++)
        begin
            sum = {1'b0, int_reg[i]} + {1'b0, cfg_reg.step_up};
            int_next[i] = int_reg[i];
            if (raw_reg[i])
            begin
                if (sum >= {1'b0, LEVEL})
                begin
                    int_next[i] = LEVEL;
                    h[i] = 1'b1;
                end
                else
                begin
                    int_next[i] = sum[INT_W-1:0];
                end
            end
            else if (int_reg[i] <= cfg_reg.step_down)
            begin
                int_next[i] = '0;
                h[i] = 1'b0;
            end
            else
            begin
                int_next[i] = int_reg[i] - cfg_reg.step_down;
            end
        end

        // set first, clear wins
        if (jx_reg > cfg_reg.upper_press)   h[BIT_RIGHT] = 1'b1;
        if (jx_reg < cfg_reg.upper_release) h[BIT_RIGHT] = 1'b0;
        if (jx_reg < cfg_reg.lower_press)   h[BIT_LEFT]  = 1'b1;
        if (jx_reg > cfg_reg.lower_release) h[BIT_LEFT]  = 1'b0;
        if (jy_reg > cfg_reg.upper_press)   h[BIT_UP]    = 1'b1;
        if (jy_reg < cfg_reg.upper_release) h[BIT_UP]    = 1'b0;
        if (jy_reg < cfg_reg.lower_press)   h[BIT_DOWN]  = 1'b1;
        if (jy_reg > cfg_reg.lower_release) h[BIT_DOWN]  = 1'b0;

        held_next = h & KEEP_MASK;

        for (int i = 0; i < MASK_W; i++)
        begin
            repeats[i]    = 1'b0;
            cnt_next[i]   = '0;
            phase_next[i] = '0;
            bumped        = 1'b0;
            c             = '0;
            p             = '0;
            if (held_next[i])
            begin
                bumped = (cnt_reg[i] != COUNT_MAX);
                c = cnt_reg[i] + CNT_W'(bumped);
                cnt_next[i]   = c;
                phase_next[i] = phase_reg[i];
                if (bumped && c == cfg_reg.repeat_initial)
                begin
                    repeats[i]    = 1'b1;
                    phase_next[i] = '0;
                end
                else if (c >= cfg_reg.repeat_initial)
                begin
                    p = {1'b0, phase_reg[i]} + 1'b1;
                    if (p >= {1'b0, cfg_reg.repeat_period})
                    begin
                        repeats[i] = 1'b1;
                        p = '0;
                    end
                    phase_next[i] = p[CNT_W-1:0];
                end
            end
        end

        press = ((~held_reg & held_next) | repeats) & KEEP_MASK;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            for (int i = 0; i < RAW_W; i++)
            begin
                int_reg[i] <= '0;
            end
            for (int i = 0; i < MASK_W; i++)
            begin
                cnt_reg[i]   <= '0;
                phase_reg[i] <= '0;
            end
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (take)
            begin
                held_reg <= held_next;
                for (int i = 0; i < RAW_W; i++)
                begin
                    int_reg[i] <= int_next[i];
                end
                for (int i = 0; i < MASK_W; i++)
                begin
                    cnt_reg[i]   <= cnt_next[i];
                    phase_reg[i] <= phase_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            raw_reg <= sample.raw_buttons;
            jx_reg  <= sample.joy_x;
            jy_reg  <= sample.joy_y;
        end
        if (take)
        begin
            held_out_reg  <= held_next;
            press_out_reg <= press;
        end
    end

`ifndef SYNTH
    a_press_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((press_out_reg & ~held_out_reg) == '0))
        else $error("press reported on a channel that is not held");

    a_missing_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((held_out_reg | press_out_reg) & ~KEEP_MASK) == '0))
        else $error("missing channel reported");

    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(raw_reg)))
        else $error("input register lost a word under stall");

    a_held_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(held_reg))
        else $error("held state changed without a word");

    a_int_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (int_reg[0] <= LEVEL) && (int_reg[RAW_W-1] <= LEVEL))
        else $error("integrator above debounce level");
`endif

endmodule
